/* design/prmd_pkg.sv */
// shared types, codes and dither matrices for the palette remap block
`default_nettype none

package prmd_pkg;

  localparam logic [1:0] KIND_LOAD_SRC = 2'd0;
  localparam logic [1:0] KIND_LOAD_TGT = 2'd1;
  localparam logic [1:0] KIND_BUILD    = 2'd2;
  localparam logic [1:0] KIND_PIXEL    = 2'd3;

  localparam logic [2:0] MODE_NEAREST  = 3'd0;
  localparam logic [2:0] MODE_CHECKER  = 3'd1;
  localparam logic [2:0] MODE_BAYER4   = 3'd2;
  localparam logic [2:0] MODE_BAYER8   = 3'd3;
  localparam logic [2:0] MODE_KEEP     = 3'd7;

  localparam logic [1:0] REG_DEPTH     = 2'd0;
  localparam logic [1:0] REG_MODE      = 2'd1;

  localparam int DIST_W = 27;
  localparam logic [DIST_W-1:0] DIST_INIT = 27'd99999999;
  localparam int NUM_W = DIST_W + 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry_index;
    logic [31:0] color_word;
    logic [7:0]  pixel_index;
    logic [2:0]  col_phase;
    logic [2:0]  row_phase;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       is_build_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_B_SRC,
    ST_B_TGT,
    ST_B_DIFF,
    ST_B_SQ,
    ST_B_CMP,
    ST_B_FIN,
    ST_B_LOG,
    ST_B_DIV,
    ST_B_WR,
    ST_DONE
  } state_t;

  function automatic logic [3:0] bayer4(input logic [3:0] idx);
    logic [3:0] v;
    case (idx)
      4'd0: v = 4'd0;    4'd1: v = 4'd8;    4'd2: v = 4'd2;    4'd3: v = 4'd10;
      4'd4: v = 4'd12;   4'd5: v = 4'd4;    4'd6: v = 4'd14;   4'd7: v = 4'd6;
      4'd8: v = 4'd3;    4'd9: v = 4'd11;   4'd10: v = 4'd1;   4'd11: v = 4'd9;
      4'd12: v = 4'd15;  4'd13: v = 4'd7;   4'd14: v = 4'd13;  default: v = 4'd5;
    endcase
    return v;
  endfunction

  localparam logic [5:0] BAYER8_TAB [64] = '{
    6'd0, 6'd32, 6'd8, 6'd40, 6'd2, 6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4, 6'd36, 6'd14, 6'd46, 6'd6, 6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3, 6'd35, 6'd11, 6'd43, 6'd1, 6'd33, 6'd9, 6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7, 6'd39, 6'd13, 6'd45, 6'd5, 6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

endpackage

`default_nettype wire

/* design/prmd_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module prmd_div
  import prmd_pkg::*;
#(
  parameter int W = NUM_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [W-1:0]      num,
  input  wire logic [DIST_W-1:0] den,
  output logic                   done,
  output logic [W-1:0]           quot
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W:0]       rem;
  logic [W-1:0]     den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;

  assign trial = {rem[W-1:0], quot[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(W);
        rem   <= '0;
        quot  <= num;
        den_q <= W'(den);
      end else if (busy) begin
        if (trial >= {1'b0, den_q}) begin
          rem  <= trial - {1'b0, den_q};
          quot <= {quot[W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/palette_remap_ordered_dither.sv */
// palette remap with nearest / second-nearest tables and ordered dither
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | into      | in_valid / in_stall | in_item (kind, index, color, ...)
//  out     | out of    | out_valid/out_stall | out_item (pixel_out, build flag)
//  cfg     | into      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// palette loads are written as they are accepted and give no transfer on the out channel
// a pixel passes in order through accept, registered table read, result into the out register
// a build (skipped in keep mode at depth 8) visits every source entry; per target color
//   an entry goes through target read, difference, five passes of the shared squarer
//   and compare, then through the log steps and the divider unless secd is zero
// rst is synchronous; palettes and tables hold nothing defined until written
// in_stall is high while an item is at work; the out register holds a result
//   under out_stall while the next item is already accepted
`default_nettype none

module palette_remap_ordered_dither
  import prmd_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int IW = $clog2(PALETTE_ENTRIES);

  // configuration registers
  logic [3:0] depth_bits;
  logic [2:0] mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_bits <= 4'd8;
      mode       <= MODE_NEAREST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEPTH: depth_bits <= cfg_data[3:0];
        REG_MODE:  mode       <= cfg_data[2:0];
        default:   ;
      endcase
    end
  end

  // effective target color count, capped by depth 8 and by the palette size
  logic [3:0]    eff_depth;
  logic [8:0]    count_raw;
  logic [8:0]    count;
  logic [IW-1:0] count_m1;

  assign eff_depth = (depth_bits > 4'd8) ? 4'd8 : depth_bits;
  assign count_raw = 9'd1 << eff_depth;
  assign count     = (count_raw > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES) : count_raw;
  assign count_m1  = IW'(count - 9'd1);

  state_t   state, state_next;
  in_item_t item_q;
  logic     in_xfer;
  logic     out_load;

  assign in_xfer = in_valid && !in_stall;

  // build bookkeeping
  logic [IW-1:0]     i_cnt;
  logic [IW-1:0]     j_cnt;
  logic [DIST_W-1:0] bestd, secd;
  logic [IW-1:0]     best, sec;
  logic [2:0]        sq_step;
  logic [19:0]       acc;
  logic signed [8:0] dr, dg, db, dy, da;
  logic [DIST_W-1:0] w;
  logic [4:0]        e;
  logic              log_sel;
  logic [DIST_W-1:0] d1;
  logic              ratio_zero;

  // memories
  logic [31:0] src_mem   [PALETTE_ENTRIES];
  logic [31:0] tgt_mem   [PALETTE_ENTRIES];
  logic [7:0]  near_mem  [PALETTE_ENTRIES];
  logic [7:0]  sec_mem   [PALETTE_ENTRIES];
  logic [7:0]  ratio_mem [PALETTE_ENTRIES];
  logic [31:0] src_rd, tgt_rd;
  logic [7:0]  near_rd, sec_rd, ratio_rd;

  logic idx_ok;
  assign idx_ok = {1'b0, in_item.entry_index} < 9'(PALETTE_ENTRIES);

  // divider hookup
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [DIST_W-1:0] log_v, log_d;

  assign log_v = log_sel ? secd : bestd;
  assign log_d = log_v >> e[4:1];

  prmd_div #(.W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({d1, 7'd0}),
    .den   (log_d),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_xfer && idx_ok && in_item.kind == KIND_LOAD_SRC) begin
      src_mem[in_item.entry_index[IW-1:0]] <= in_item.color_word;
    end
    if (in_xfer && idx_ok && in_item.kind == KIND_LOAD_TGT) begin
      tgt_mem[in_item.entry_index[IW-1:0]] <= in_item.color_word;
    end
    src_rd <= src_mem[i_cnt];
    tgt_rd <= tgt_mem[j_cnt];
  end

  always_ff @(posedge clk) begin
    if (state == ST_B_WR) begin
      near_mem[i_cnt]  <= 8'(best);
      sec_mem[i_cnt]   <= 8'(sec);
      ratio_mem[i_cnt] <= ratio_zero ? 8'd0 : div_quot[7:0];
    end
    near_rd  <= near_mem[item_q.pixel_index[IW-1:0]];
    sec_rd   <= sec_mem[item_q.pixel_index[IW-1:0]];
    ratio_rd <= ratio_mem[item_q.pixel_index[IW-1:0]];
  end

  // shared squarer: one weighted square added per cycle
  logic signed [8:0]  sq_op;
  logic signed [17:0] sq_raw;
  logic [18:0]        sq_w;
  logic [9:0]         ya, yb;

  always_comb begin
    case (sq_step)
      3'd0:    sq_op = dr;
      3'd1:    sq_op = dg;
      3'd2:    sq_op = db;
      3'd3:    sq_op = dy;
      default: sq_op = da;
    endcase
    sq_raw = sq_op * sq_op;
    case (sq_step)
      3'd3:    sq_w = {2'b0, sq_raw[15:0], 1'b0};
      3'd4:    sq_w = {sq_raw[15:0], 3'b0};
      default: sq_w = {3'b0, sq_raw[15:0]};
    endcase
  end

  assign ya = ({2'b0, src_rd[15:8]} << 1) + {2'b0, src_rd[23:16]} + {2'b0, src_rd[7:0]};
  assign yb = ({2'b0, tgt_rd[15:8]} << 1) + {2'b0, tgt_rd[23:16]} + {2'b0, tgt_rd[7:0]};

  logic [DIST_W-1:0] acc_ext;
  assign acc_ext = DIST_W'(acc);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_item.kind == KIND_PIXEL) begin
            state_next = ST_PIX_RD;
          end else if (in_item.kind == KIND_BUILD) begin
            state_next = (mode == MODE_KEEP && eff_depth == 4'd8) ? ST_DONE : ST_B_SRC;
          end
        end
      end
      ST_PIX_RD: state_next = ST_DONE;
      ST_B_SRC:  state_next = ST_B_TGT;
      ST_B_TGT:  state_next = ST_B_DIFF;
      ST_B_DIFF: state_next = ST_B_SQ;
      ST_B_SQ:   state_next = (sq_step == 3'd4) ? ST_B_CMP : ST_B_SQ;
      ST_B_CMP:  state_next = (j_cnt == count_m1) ? ST_B_FIN : ST_B_TGT;
      ST_B_FIN:  state_next = (secd == '0) ? ST_B_WR : ST_B_LOG;
      ST_B_LOG:  state_next = (w <= DIST_W'(1) && log_sel) ? ST_B_DIV : ST_B_LOG;
      ST_B_DIV:  state_next = div_done ? ST_B_WR : ST_B_DIV;
      ST_B_WR:   state_next = (i_cnt == IW'(PALETTE_ENTRIES - 1)) ? ST_DONE : ST_B_SRC;
      ST_DONE:   state_next = out_load ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_B_LOG: div_start = (w <= DIST_W'(1)) && log_sel;
      ST_DONE:  out_load  = !out_valid || !out_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // build datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_q <= in_item;
      i_cnt  <= '0;
    end
    unique case (state)
      ST_B_SRC: begin
        j_cnt <= '0;
        best  <= '0;
        sec   <= '0;
        bestd <= DIST_INIT;
        secd  <= DIST_INIT;
      end
      ST_B_DIFF: begin
        dr      <= $signed({1'b0, src_rd[23:16]}) - $signed({1'b0, tgt_rd[23:16]});
        dg      <= $signed({1'b0, src_rd[15:8]})  - $signed({1'b0, tgt_rd[15:8]});
        db      <= $signed({1'b0, src_rd[7:0]})   - $signed({1'b0, tgt_rd[7:0]});
        da      <= $signed({1'b0, src_rd[31:24]}) - $signed({1'b0, tgt_rd[31:24]});
        dy      <= $signed({1'b0, ya[9:2]}) - $signed({1'b0, yb[9:2]});
        acc     <= '0;
        sq_step <= '0;
      end
      ST_B_SQ: begin
        acc     <= acc + 20'(sq_w);
        sq_step <= sq_step + 3'd1;
      end
      ST_B_CMP: begin
        if (acc_ext < bestd) begin
          sec   <= best;
          secd  <= bestd;
          best  <= j_cnt;
          bestd <= acc_ext;
        end else if (acc_ext < secd) begin
          sec  <= j_cnt;
          secd <= acc_ext;
        end
        j_cnt <= j_cnt + 1'b1;
      end
      ST_B_FIN: begin
        // second choice collapses to the nearest when that is far closer
        if ({bestd, 2'b00} < {2'b00, secd}) begin
          sec <= best;
        end
        ratio_zero <= (secd == '0);
        w          <= bestd;
        e          <= '0;
        log_sel    <= 1'b0;
      end
      ST_B_LOG: begin
        if (w > DIST_W'(1)) begin
          w <= DIST_W'(({1'b0, w} + 1'b1) >> 1);
          e <= e + 5'd1;
        end else if (!log_sel) begin
          d1      <= log_d;
          w       <= secd;
          e       <= '0;
          log_sel <= 1'b1;
        end
      end
      ST_B_WR: i_cnt <= i_cnt + 1'b1;
      default: ;
    endcase
  end

  // pixel remap from the registered table reads
  logic       pix_ok;
  logic [7:0] n_v, s_v, r_v;
  logic [7:0] pix_res;
  logic [3:0] b4;
  logic [5:0] b8;

  assign pix_ok = {1'b0, item_q.pixel_index} < 9'(PALETTE_ENTRIES);
  assign n_v    = pix_ok ? near_rd : 8'd0;
  assign s_v    = pix_ok ? sec_rd : 8'd0;
  assign r_v    = pix_ok ? ratio_rd : 8'd0;
  assign b4     = bayer4({item_q.row_phase[1:0], item_q.col_phase[1:0]});
  assign b8     = BAYER8_TAB[{item_q.row_phase, item_q.col_phase}];

  always_comb begin
    case (mode)
      MODE_NEAREST: pix_res = n_v;
      MODE_CHECKER: pix_res = (item_q.col_phase[0] ^ item_q.row_phase[0]) ? s_v : n_v;
      MODE_BAYER4:  pix_res = (r_v > {b4, 4'd0}) ? s_v : n_v;
      MODE_BAYER8:  pix_res = (r_v > {b8, 2'd0}) ? s_v : n_v;
      MODE_KEEP:    pix_res = ({1'b0, item_q.pixel_index} >= count) ? n_v : item_q.pixel_index;
      default:      pix_res = item_q.pixel_index;
    endcase
  end

  // out register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (item_q.kind == KIND_BUILD) begin
        out_item.pixel_out     <= 8'd0;
        out_item.is_build_done <= 1'b1;
      end else begin
        out_item.pixel_out     <= pix_res;
        out_item.is_build_done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/prmd_chk.sv */
// port checker for the palette remap block and its bind
`default_nettype none

module prmd_chk
  import prmd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result dropped or changed");

  a_build_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_build_done |-> out_item.pixel_out == 8'd0)
    else $error("build transfer carries a pixel value");

  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.kind == KIND_BUILD || in_item.kind == KIND_PIXEL)
    |=> in_stall)
    else $error("input taken while an item is at work");

  a_no_result_from_load: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_stall ##1 in_stall == 1'b0 |-> !out_valid)
    else $error("result appeared with no item at work");

endmodule

bind palette_remap_ordered_dither prmd_chk u_prmd_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
